// ----- design/sspc_pkg.sv -----
package sspc_pkg;

  // Number of entries in each packet buffer (2 to 256).
  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  localparam int POS_W  = 6;
  localparam int BYTE_W = 8;
  localparam int TICK_W = 8;

  typedef logic [BUF_AW-1:0] buf_addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam pos_t  LAST_INDEX_RESET = 6'd63;
  localparam tick_t IDLE_RESET_TICKS = 8'd5;
  localparam tick_t IDLE_LIMIT       = 8'd250;

  typedef enum logic [1:0] {
    CMD_SPI_BYTE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_TX_WRITE = 2'd2,
    CMD_RX_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CSUM_ERR = 2'd2
  } status_e;

  // Buffer accesses issued when a request is accepted.
  typedef struct packed {
    logic  tx_we;
    logic  tx_re;
    pos_t  tx_addr;
    byte_t tx_wdata;
    logic  rx_we;
    logic  rx_re;
    pos_t  rx_addr;
    byte_t rx_wdata;
  } mem_req_t;

  // What the reply stage needs to know about a request in flight.
  typedef struct packed {
    cmd_e    cmd;
    logic    good;
    status_e status;
    logic    clr_tx_sum;
    logic    is_last;
  } s1_info_t;

  function automatic logic in_buf(input pos_t idx);
    return ({3'b000, idx} < 9'(BUF_DEPTH));
  endfunction

  function automatic buf_addr_t to_addr(input pos_t idx);
    return buf_addr_t'(idx);
  endfunction

endpackage

// ----- design/sspc_if.sv -----
interface sspc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] mosi_byte;
  logic [5:0] buf_index;
  logic [7:0] buf_data;

  modport source (output valid, output cmd, output mosi_byte, output buf_index,
                  output buf_data, input ready);
  modport sink (input valid, input cmd, input mosi_byte, input buf_index,
                input buf_data, output ready);
endinterface

interface sspc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;
  logic       packet_good;
  logic [1:0] link_status;
  logic [7:0] read_data;

  modport source (output valid, output miso_byte, output packet_good,
                  output link_status, output read_data, input ready);
  modport sink (input valid, input miso_byte, input packet_good,
                input link_status, input read_data, output ready);
endinterface

// ----- design/sspc_frame_ctl.sv -----
module sspc_frame_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  sspc_pkg::pos_t     cfg_wdata_i,
  input  logic               acc_i,
  input  sspc_pkg::cmd_e     cmd_i,
  input  sspc_pkg::byte_t    mosi_byte_i,
  input  sspc_pkg::pos_t     buf_index_i,
  input  sspc_pkg::byte_t    buf_data_i,
  output sspc_pkg::mem_req_t mem_req_o,
  output sspc_pkg::s1_info_t info_o
);

  sspc_pkg::pos_t    last_q;
  sspc_pkg::pos_t    pos_q, pos_d;
  sspc_pkg::byte_t   rx_sum_q, rx_sum_d;
  sspc_pkg::tick_t   idle_q, idle_d;
  sspc_pkg::status_e status_q, status_d;
  sspc_pkg::byte_t   rx_sum_new;
  sspc_pkg::tick_t   tick_new;

  assign rx_sum_new = rx_sum_q + mosi_byte_i;
  assign tick_new   = idle_q + 8'd1;

  always_comb begin
    pos_d             = pos_q;
    rx_sum_d          = rx_sum_q;
    idle_d            = idle_q;
    status_d          = status_q;
    mem_req_o         = '0;
    info_o.cmd        = cmd_i;
    info_o.good       = 1'b0;
    info_o.clr_tx_sum = 1'b0;
    info_o.is_last    = 1'b0;
    if (acc_i) begin
      unique case (cmd_i)
        sspc_pkg::CMD_SPI_BYTE: begin
          idle_d             = '0;
          status_d           = sspc_pkg::ST_OK;
          mem_req_o.rx_we    = sspc_pkg::in_buf(pos_q);
          mem_req_o.rx_addr  = pos_q;
          mem_req_o.rx_wdata = mosi_byte_i;
          if (pos_q == last_q) begin
            info_o.good       = (rx_sum_new == '0);
            status_d          = info_o.good ? sspc_pkg::ST_OK : sspc_pkg::ST_CSUM_ERR;
            pos_d             = '0;
            rx_sum_d          = '0;
            info_o.clr_tx_sum = 1'b1;
          end else begin
            pos_d    = pos_q + 6'd1;
            rx_sum_d = rx_sum_new;
          end
          mem_req_o.tx_re   = 1'b1;
          mem_req_o.tx_addr = pos_d;
          info_o.is_last    = (pos_d == last_q);
        end
        sspc_pkg::CMD_TICK: begin
          idle_d = tick_new;
          if (tick_new == sspc_pkg::IDLE_RESET_TICKS) begin
            pos_d             = '0;
            rx_sum_d          = '0;
            info_o.clr_tx_sum = 1'b1;
          end
          if (tick_new > sspc_pkg::IDLE_LIMIT) begin
            status_d = sspc_pkg::ST_TIMEOUT;
            idle_d   = sspc_pkg::IDLE_RESET_TICKS;
          end
        end
        sspc_pkg::CMD_TX_WRITE: begin
          mem_req_o.tx_we    = 1'b1;
          mem_req_o.tx_addr  = buf_index_i;
          mem_req_o.tx_wdata = buf_data_i;
        end
        sspc_pkg::CMD_RX_READ: begin
          mem_req_o.rx_re   = 1'b1;
          mem_req_o.rx_addr = buf_index_i;
        end
        default: begin
        end
      endcase
    end
    info_o.status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= sspc_pkg::LAST_INDEX_RESET;
      pos_q    <= '0;
      rx_sum_q <= '0;
      idle_q   <= '0;
      status_q <= sspc_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        last_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      rx_sum_q <= rx_sum_d;
      idle_q   <= idle_d;
      status_q <= status_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q <= sspc_pkg::IDLE_LIMIT)
    else $error("idle tick count ran past its limit");

  a_wrap_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && cmd_i == sspc_pkg::CMD_SPI_BYTE && pos_q == last_q && !cfg_we_i
    |=> pos_q == '0 && rx_sum_q == '0)
    else $error("framing did not restart after the last packet byte");

  a_byte_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && cmd_i == sspc_pkg::CMD_SPI_BYTE |=> idle_q == '0)
    else $error("received byte did not clear the idle count");
`endif

endmodule

// ----- design/sspc_buffers.sv -----
module sspc_buffers (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sspc_pkg::mem_req_t mem_req_i,
  output sspc_pkg::byte_t    tx_byte_o,
  output sspc_pkg::byte_t    rx_byte_o
);

  sspc_pkg::byte_t tx_mem [sspc_pkg::BUF_DEPTH];
  sspc_pkg::byte_t rx_mem [sspc_pkg::BUF_DEPTH];

  // Transmit entries read as zero until software writes them.
  logic [sspc_pkg::BUF_DEPTH-1:0] tx_valid_q;

  sspc_pkg::buf_addr_t tx_addr, rx_addr;
  logic                tx_in, rx_in;
  sspc_pkg::byte_t     tx_rdata_q, rx_rdata_q;
  logic                tx_hit_q, rx_hit_q;

  assign tx_addr = sspc_pkg::to_addr(mem_req_i.tx_addr);
  assign rx_addr = sspc_pkg::to_addr(mem_req_i.rx_addr);
  assign tx_in   = sspc_pkg::in_buf(mem_req_i.tx_addr);
  assign rx_in   = sspc_pkg::in_buf(mem_req_i.rx_addr);

  always_ff @(posedge clk_i) begin
    if (mem_req_i.tx_we && tx_in) begin
      tx_mem[tx_addr] <= mem_req_i.tx_wdata;
    end
    if (mem_req_i.tx_re) begin
      tx_rdata_q <= tx_mem[tx_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rx_we && rx_in) begin
      rx_mem[rx_addr] <= mem_req_i.rx_wdata;
    end
    if (mem_req_i.rx_re) begin
      rx_rdata_q <= rx_mem[rx_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid_q <= '0;
      tx_hit_q   <= 1'b0;
      rx_hit_q   <= 1'b0;
    end else begin
      if (mem_req_i.tx_we && tx_in) begin
        tx_valid_q[tx_addr] <= 1'b1;
      end
      if (mem_req_i.tx_re) begin
        tx_hit_q <= tx_in && tx_valid_q[tx_addr];
      end
      if (mem_req_i.rx_re) begin
        rx_hit_q <= rx_in;
      end
    end
  end

  assign tx_byte_o = tx_hit_q ? tx_rdata_q : '0;
  assign rx_byte_o = rx_hit_q ? rx_rdata_q : '0;

endmodule

// ----- design/sspc_reply.sv -----
module sspc_reply (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  sspc_pkg::s1_info_t info_i,
  input  sspc_pkg::byte_t    tx_byte_i,
  input  sspc_pkg::byte_t    rx_byte_i,
  output logic               take_o,
  sspc_rsp_if.source         rsp
);

  logic               s1_valid_q;
  sspc_pkg::s1_info_t s1_info_q;
  logic               out_valid_q;
  logic               out_free, s1_adv;
  sspc_pkg::byte_t    tx_sum_q, tx_sum_d;
  sspc_pkg::byte_t    sum_base, sum_new;
  sspc_pkg::byte_t    miso, rdata;
  sspc_pkg::byte_t    miso_q, rdata_q;
  logic               good_q;
  sspc_pkg::status_e  status_q;

  assign out_free = !out_valid_q || rsp.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign take_o   = !s1_valid_q || out_free;

  assign sum_base = s1_info_q.clr_tx_sum ? '0 : tx_sum_q;
  assign sum_new  = sum_base + tx_byte_i;

  always_comb begin
    tx_sum_d = tx_sum_q;
    miso     = '0;
    rdata    = '0;
    unique case (s1_info_q.cmd)
      sspc_pkg::CMD_SPI_BYTE: begin
        tx_sum_d = sum_new;
        miso     = s1_info_q.is_last ? 8'(8'd0 - sum_new) : tx_byte_i;
      end
      sspc_pkg::CMD_TICK: begin
        if (s1_info_q.clr_tx_sum) begin
          tx_sum_d = '0;
        end
      end
      sspc_pkg::CMD_RX_READ: begin
        rdata = rx_byte_i;
      end
      sspc_pkg::CMD_TX_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tx_sum_q    <= '0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        tx_sum_q    <= tx_sum_d;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_info_q <= info_i;
    end
    if (s1_adv) begin
      miso_q   <= miso;
      rdata_q  <= rdata;
      good_q   <= s1_info_q.good;
      status_q <= s1_info_q.status;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.miso_byte   = miso_q;
  assign rsp.packet_good = good_q;
  assign rsp.link_status = status_q;
  assign rsp.read_data   = rdata_q;

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result left the reply stage but no response is pending");

  a_accept_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> take_o)
    else $error("request accepted while the reply stage was full");
`endif

endmodule

// ----- design/spi_slave_packet_checksum_unit.sv -----
// SPI slave packet framer with an 8-bit additive checksum. Every request on
// req_i gives exactly one response on rsp_o, in order. A received SPI byte is
// stored in the receive buffer at the running packet position and summed; at
// the last index (cfg register, reset 63) a zero sum pulses packet_good and a
// nonzero sum reports a checksum error, and framing restarts. The reply byte
// is the transmit buffer entry at the next position, or the two's complement
// of the transmit sum at the checksum slot. Timer ticks count idle time and
// restart framing after five ticks, reporting a timeout past 250. Software
// fills the transmit buffer and reads the receive buffer through requests.
// The block sustains one request per clock cycle while responses are taken.
// The buffer RAMs are read at the edge that accepts a request, and the output
// register loads at a later edge, once no untaken response holds it. The
// transmit buffer reads as zero from reset until an entry is written, so no
// clearing pass is needed.
module spi_slave_packet_checksum_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  sspc_pkg::pos_t cfg_wdata_i,
  sspc_req_if.sink       req_i,
  sspc_rsp_if.source     rsp_o
);

  logic               acc;
  logic               take;
  sspc_pkg::mem_req_t mem_req;
  sspc_pkg::s1_info_t info;
  sspc_pkg::byte_t    tx_byte;
  sspc_pkg::byte_t    rx_byte;

  // A request is taken whenever the reply stage can move its current
  // result into the output register, so a waiting response never blocks
  // the next request by itself.
  assign req_i.ready = take;
  assign acc         = req_i.valid && take;

  // Framing state, the receive sum, the idle counter and the status all
  // update in the cycle the request is accepted; buffer accesses issue then.
  sspc_frame_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .cmd_i       (sspc_pkg::cmd_e'(req_i.cmd)),
    .mosi_byte_i (req_i.mosi_byte),
    .buf_index_i (req_i.buf_index),
    .buf_data_i  (req_i.buf_data),
    .mem_req_o   (mem_req),
    .info_o      (info)
  );

  // Receive and transmit buffers, one synchronous RAM each.
  sspc_buffers u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .tx_byte_o (tx_byte),
    .rx_byte_o (rx_byte)
  );

  // The transmit sum lives next to the RAM read data it accumulates, so the
  // reply byte and the checksum slot are formed in the cycle after acceptance.
  sspc_reply u_reply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .info_i    (info),
    .tx_byte_i (tx_byte),
    .rx_byte_i (rx_byte),
    .take_o    (take),
    .rsp       (rsp_o)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sspc_pkg::*;

  // The run stops on this many clock cycles whatever else happens. The
  // slowest correct run is around ITEM_TARGET requests, each with a sender gap,
  // a response stall and the pipeline latency, plus the drains around register
  // writes.
  localparam int CYCLE_LIMIT  = 200_000;
  // Random stimulus stops once this many requests have gone in.
  localparam int ITEM_TARGET  = 1350;
  // The last stretch of the run goes without any idling on either side.
  localparam int STEADY_TAIL  = 150;
  // Quiet cycles waited once no response is owed; this leaves some margin.
  localparam int DRAIN_CYCLES = 4;

  // One request as the block sees it.
  typedef struct packed {
    cmd_e  cmd;
    byte_t mosi;
    pos_t  idx;
    byte_t data;
  } spi_req_t;

  // One response as the block should produce it.
  typedef struct packed {
    byte_t   miso;
    logic    good;
    status_e status;
    byte_t   rdata;
  } reply_t;

  // A row of the directed table. A register row writes idx as the new last
  // index. A row marked typed carries its response written out by hand;
  // every other row is checked against the predictor.
  typedef struct {
    bit      is_cfg;
    cmd_e    cmd;
    byte_t   mosi;
    pos_t    idx;
    byte_t   data;
    bit      typed;
    byte_t   miso;
    logic    good;
    status_e status;
    byte_t   rdata;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  pos_t cfg_wdata;

  sspc_req_if req_bus ();
  sspc_rsp_if rsp_bus ();

  spi_slave_packet_checksum_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // Predictor state: our own copy of the framer, updated once per accepted
  // request. rx_seen marks receive entries that hold a real byte, so that
  // the stimulus never reads an entry that was never written.
  byte_t   rx_mem  [BUF_DEPTH];
  bit      rx_seen [BUF_DEPTH];
  byte_t   tx_mem  [BUF_DEPTH];
  pos_t    pos;
  byte_t   rx_acc;
  byte_t   tx_acc;
  tick_t   idle;
  status_e link;
  pos_t    last_idx;

  // Responses still owed by the block, oldest first.
  reply_t reply_q[$];

  int unsigned req_count;
  int unsigned mismatch_count;
  int unsigned cycles;

  // Idling is switched off for whole phases now and then, and for good once
  // the run reaches its final stretch.
  bit calm_phase;
  bit in_tail;

  // Directed requests. They walk the field extremes, every command, a good
  // packet and a checksum error at two packet lengths, the framing restart
  // after five idle ticks, a one-byte packet and a return to the reset length.
  row_t plan [25] = '{
    // A tick straight after reset: nothing but zeros comes back.
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b1, 8'h00, 1'b0, ST_OK,       8'h00},
    // First byte of a packet; the transmit buffer is still all zeros.
    '{1'b0, CMD_SPI_BYTE, 8'hFF, 6'd0,  8'h00, 1'b1, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_RX_READ,  8'h00, 6'd0,  8'h00, 1'b1, 8'h00, 1'b0, ST_OK,       8'hFF},
    '{1'b0, CMD_TX_WRITE, 8'h00, 6'd63, 8'hFF, 1'b1, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TX_WRITE, 8'h00, 6'd0,  8'h80, 1'b1, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TX_WRITE, 8'h00, 6'd1,  8'h7F, 1'b1, 8'h00, 1'b0, ST_OK,       8'h00},
    // Five idle ticks drop the half-received packet.
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    // Two-byte packets: one that sums to zero, then one that does not.
    '{1'b1, CMD_TICK,     8'h00, 6'd1,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'h01, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'hFF, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'h05, 6'd0,  8'h00, 1'b1, 8'h80, 1'b0, ST_CSUM_ERR, 8'h00},
    // The error status survives a tick.
    '{1'b0, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    // One-byte packets: every byte closes a packet and the reply is the
    // negated transmit sum.
    '{1'b1, CMD_TICK,     8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'h00, 6'd0,  8'h00, 1'b1, 8'h80, 1'b1, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'hAA, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    // Back to the reset length.
    '{1'b1, CMD_TICK,     8'h00, 6'd63, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_RX_READ,  8'h00, 6'd1,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_TX_WRITE, 8'h00, 6'd62, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_SPI_BYTE, 8'h7E, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00},
    '{1'b0, CMD_RX_READ,  8'h00, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, ST_OK,       8'h00}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the predicted framer by one accepted request and return the
  // response it owes.
  function automatic reply_t framer_step(spi_req_t r);
    reply_t rep;
    byte_t  slot;
    rep = '{miso: '0, good: 1'b0, status: ST_OK, rdata: '0};
    case (r.cmd)
      CMD_SPI_BYTE: begin
        idle = '0;
        link = ST_OK;
        if (int'(pos) < BUF_DEPTH) begin
          rx_mem[pos]  = r.mosi;
          rx_seen[pos] = 1'b1;
        end
        rx_acc = rx_acc + r.mosi;
        if (pos == last_idx) begin
          // Packet complete: a zero sum is good, anything else an error.
          if (rx_acc == '0) begin
            rep.good = 1'b1;
          end else begin
            link = ST_CSUM_ERR;
          end
          pos    = '0;
          rx_acc = '0;
          tx_acc = '0;
        end else begin
          // The position wraps at 64 if the last index was set below it.
          pos = pos + 1'b1;
        end
        slot   = (int'(pos) < BUF_DEPTH) ? tx_mem[pos] : '0;
        tx_acc = tx_acc + slot;
        // The checksum slot carries the two's complement of the reply sum.
        rep.miso = (pos == last_idx) ? byte_t'(8'd0 - tx_acc) : slot;
      end
      CMD_TICK: begin
        idle = idle + 1'b1;
        if (idle == IDLE_RESET_TICKS) begin
          pos    = '0;
          rx_acc = '0;
          tx_acc = '0;
        end
        if (idle > IDLE_LIMIT) begin
          link = ST_TIMEOUT;
          idle = IDLE_RESET_TICKS;
        end
      end
      CMD_TX_WRITE: begin
        if (int'(r.idx) < BUF_DEPTH) begin
          tx_mem[r.idx] = r.data;
        end
      end
      default: begin
        rep.rdata = (int'(r.idx) < BUF_DEPTH) ? rx_mem[r.idx] : '0;
      end
    endcase
    rep.status = link;
    return rep;
  endfunction

  // First receive entry at or after start that holds a real byte.
  function automatic pos_t written_near(pos_t start);
    pos_t i;
    i = start;
    repeat (BUF_DEPTH) begin
      if (rx_seen[i]) begin
        return i;
      end
      i = i + 1'b1;
    end
    return start;
  endfunction

  task automatic report(string what, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("tb: %s: expected %02h, got %02h at %0t", what, want, got, $realtime);
    end
  endtask

  // Present one request and hold it until the block takes it. An idle burst
  // may come first, unless idling is off.
  task automatic send_req(spi_req_t r, bit typed, reply_t want);
    reply_t exp;
    if (!(calm_phase || in_tail) && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.cmd       <= r.cmd;
    req_bus.mosi_byte <= r.mosi;
    req_bus.buf_index <= r.idx;
    req_bus.buf_data  <= r.data;
    do begin
      @(posedge clk_i);
    end while (req_bus.ready !== 1'b1);
    // Accepted at this edge: the predictor moves on right away, so the next
    // request is generated from the state that the block will have.
    exp = framer_step(r);
    reply_q.push_back(typed ? want : exp);
    req_count++;
    if (req_count >= ITEM_TARGET - STEADY_TAIL) begin
      in_tail = 1'b1;
    end
  endtask

  task automatic send(cmd_e c, byte_t mosi, pos_t idx, byte_t data);
    send_req('{cmd: c, mosi: mosi, idx: idx, data: data}, 1'b0, '0);
  endtask

  // The register is only touched with the block quiet: stop requesting, let
  // every owed response come out, let the pipeline settle, then write for
  // exactly one edge.
  task automatic set_last_index(pos_t v);
    req_bus.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    last_idx = v;
  endtask

  // Response side: ready drops at random, unless idling is off.
  initial begin
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!(calm_phase || in_tail) && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
    end
  end

  // Every response taken at an edge is matched against the oldest one owed.
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        report("response with none owed, miso_byte", 8'h00, rsp_bus.miso_byte);
      end else begin
        want = reply_q.pop_front();
        if (rsp_bus.miso_byte !== want.miso) begin
          report("miso_byte", want.miso, rsp_bus.miso_byte);
        end
        if (rsp_bus.packet_good !== want.good) begin
          report("packet_good", 8'(want.good), 8'(rsp_bus.packet_good));
        end
        if (rsp_bus.link_status !== want.status) begin
          report("link_status", 8'(want.status), 8'(rsp_bus.link_status));
        end
        if (rsp_bus.read_data !== want.rdata) begin
          report("read_data", want.rdata, rsp_bus.read_data);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a response that never comes ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    reply_t want;
    int     phase;
    int     pick;
    bit     closing;
    byte_t  mosi;
    pos_t   idx;
    cmd_e   c;

    req_count      = 0;
    mismatch_count = 0;
    calm_phase     = 1'b0;
    in_tail        = 1'b0;

    // Predicted state after reset. Receive entries count as unwritten.
    for (int i = 0; i < BUF_DEPTH; i++) begin
      rx_mem[i]  = '0;
      rx_seen[i] = 1'b0;
      tx_mem[i]  = '0;
    end
    pos      = '0;
    rx_acc   = '0;
    tx_acc   = '0;
    idle     = '0;
    link     = ST_OK;
    last_idx = LAST_INDEX_RESET;

    rst_ni            = 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_bus.valid     <= 1'b0;
    req_bus.cmd       <= CMD_TICK;
    req_bus.mosi_byte <= '0;
    req_bus.buf_index <= '0;
    req_bus.buf_data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_last_index(plan[i].idx);
      end else begin
        want = '{miso: plan[i].miso, good: plan[i].good, status: plan[i].status,
                 rdata: plan[i].rdata};
        send_req('{cmd: plan[i].cmd, mosi: plan[i].mosi, idx: plan[i].idx,
                   data: plan[i].data}, plan[i].typed, want);
      end
    end

    // Random part, in phases. Each phase picks a packet length, then sends
    // mostly well-formed packets with random content, with ticks, buffer
    // traffic and plain noise mixed in.
    phase = 0;
    while (req_count < ITEM_TARGET) begin
      calm_phase = ($urandom_range(0, 4) == 0);

      if (phase == 3) begin
        // Lower the last index below the running position: the position has
        // to run up past 63 and wrap to zero before the packet can close.
        set_last_index(LAST_INDEX_RESET);
        while (pos != 6'd40) send(CMD_SPI_BYTE, byte_t'($urandom), pos_t'($urandom),
                                  byte_t'($urandom));
        set_last_index(6'd3);
      end else begin
        // Short packets most of the time so that many of them complete;
        // the extremes and full-range lengths now and then.
        pick = $urandom_range(0, 9);
        case (pick)
          0:       set_last_index(6'd0);
          1:       set_last_index(6'd63);
          2:       set_last_index(pos_t'($urandom));
          default: set_last_index(pos_t'($urandom_range(1, 7)));
        endcase
      end

      if (phase == 6) begin
        // A long silence: framing restarts at five ticks, the status turns to
        // timeout past the limit and the count falls back, then keeps going.
        repeat (int'(IDLE_LIMIT) + 6) send(CMD_TICK, byte_t'($urandom), pos_t'($urandom),
                                           byte_t'($urandom));
      end

      repeat ($urandom_range(2, 5)) begin
        // Load some reply bytes, mostly inside the coming packet.
        repeat ($urandom_range(0, 3)) begin
          idx = ($urandom_range(0, 1) == 1) ? pos_t'($urandom_range(0, int'(last_idx)))
                                            : pos_t'($urandom);
          send(CMD_TX_WRITE, byte_t'($urandom), idx, byte_t'($urandom));
        end
        closing = 1'b0;
        while (!closing) begin
          case ($urandom_range(0, 15))
            0: repeat ($urandom_range(1, 3)) send(CMD_TICK, byte_t'($urandom),
                                                   pos_t'($urandom), byte_t'($urandom));
            1: send(CMD_RX_READ, byte_t'($urandom), written_near(pos_t'($urandom)),
                    byte_t'($urandom));
            2: begin
              // Rarely the master goes quiet long enough to lose the packet.
              if ($urandom_range(0, 3) == 0) begin
                repeat (int'(IDLE_RESET_TICKS)) send(CMD_TICK, byte_t'($urandom),
                                                     pos_t'($urandom), byte_t'($urandom));
              end
            end
            default: ;
          endcase
          closing = (pos == last_idx);
          // The closing byte usually makes the packet sum to zero.
          if (closing && $urandom_range(0, 3) != 0) begin
            mosi = byte_t'(8'd0 - rx_acc);
          end else begin
            mosi = byte_t'($urandom);
          end
          send(CMD_SPI_BYTE, mosi, pos_t'($urandom), byte_t'($urandom));
        end
      end

      // Noise: any command, any field values, reads only of written entries.
      repeat ($urandom_range(0, 6)) begin
        c   = cmd_e'($urandom_range(0, 3));
        idx = pos_t'($urandom);
        if (c == CMD_RX_READ) begin
          idx = written_near(idx);
        end
        send(c, byte_t'($urandom), idx, byte_t'($urandom));
      end
      phase++;
    end

    // Let every owed response come out, then wait out the drain for anything the
    // block should not produce.
    req_bus.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
